>>> hw/rtl/grid_bearing_heading_unit_macros.svh
// Assertion helpers used by the checker file gbhu_checker.sv.
`ifndef GRID_BEARING_HEADING_UNIT_MACROS_SVH
`define GRID_BEARING_HEADING_UNIT_MACROS_SVH

// same-cycle implication
`define GBHU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBHU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/gbhu_pkg.sv
package gbhu_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int COORD_BITS    = 30;

  // fixed field widths
  localparam int FIELD_COORD_W = 30;
  localparam int ANGLE_W       = 20;
  localparam int RANGE_W       = 31;
  localparam int BEARING_W     = 20;
  localparam int HEAD_W        = 21;

  localparam int IN_FIELDS_W  = 4 * FIELD_COORD_W + 2 * ANGLE_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = RANGE_W + BEARING_W + 2 * HEAD_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // range path
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS + 1;
  localparam int ROOT_W = COORD_BITS + 1;
  localparam int TRI_W  = 2 * ROOT_W + 1;
  localparam longint unsigned RANGE_MAX = 64'h7FFF_FFFF;

  // bearing path
  localparam int NORM_BITS  = 40;
  localparam int M_W        = NORM_BITS + 1;
  localparam int NORM_STEPS = 6;
  localparam int XY_W       = NORM_BITS + 5;
  localparam int Z_W        = 32;
  localparam int TABLE_LEN  = 40;
  localparam int CIRCLE_UNITS = 640000;
  localparam int PROD_W     = Z_W + ANGLE_W;

  localparam int BRG_PATH   = NORM_STEPS + CORDIC_STAGES;
  localparam int CHAIN_LEN  = (ROOT_W > BRG_PATH) ? ROOT_W : BRG_PATH;
  localparam int NUM_STAGES = CHAIN_LEN + 7;

  localparam logic [Z_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic [SQ_W-1:0]        rem;
    logic [ROOT_W-1:0]      root;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [Z_W-1:0]         z;
    logic [M_W-1:0]         m;
    logic                   zero;
    logic                   sat;
    logic [ANGLE_W-1:0]     off;
    logic [ANGLE_W-1:0]     rd;
  } gbhu_stage_t;

endpackage

>>> hw/rtl/grid_bearing_heading_unit.sv
// Pipeline: p0, p1, p2, the CHAIN_LEN chain stages, then t1, t2, t3 and t4.
// Throughput: one word per cycle unless the output stalls; the range square root takes
// one result bit per stage and the bearing one normalize or CORDIC step per stage, side by side.
// A stalled output holds the whole pipeline.
// Reset: synchronous, active low; clears the stage valid bits only.
module grid_bearing_heading_unit
  import gbhu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // launcher_east, launcher_north, target_east, target_north,
  // orientation_offset, heading_reading
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // range_cm, bearing, relative_heading, heading_error
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int OFF_LSB = 4 * FIELD_COORD_W;
  localparam int RD_LSB  = OFF_LSB + ANGLE_W;

  logic ce;
  logic [NUM_STAGES-1:0] vld_r;

  assign ce        = !vld_r[NUM_STAGES-1] || out_tready;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_tvalid};
    end
  end

  // p0: deltas
  logic [COORD_BITS-1:0] le, ln, te, tn;
  logic signed [DIFF_W-1:0] p0_de_r, p0_dn_r;
  logic [ANGLE_W-1:0] p0_off_r, p0_rd_r;

  assign le = COORD_BITS'(in_tdata[FIELD_COORD_W-1:0]);
  assign ln = COORD_BITS'(in_tdata[2*FIELD_COORD_W-1:FIELD_COORD_W]);
  assign te = COORD_BITS'(in_tdata[3*FIELD_COORD_W-1:2*FIELD_COORD_W]);
  assign tn = COORD_BITS'(in_tdata[4*FIELD_COORD_W-1:3*FIELD_COORD_W]);

  always_ff @(posedge clk) begin
    if (ce) begin
      p0_de_r  <= $signed({1'b0, te}) - $signed({1'b0, le});
      p0_dn_r  <= $signed({1'b0, tn}) - $signed({1'b0, ln});
      p0_off_r <= in_tdata[OFF_LSB+ANGLE_W-1:OFF_LSB];
      p0_rd_r  <= in_tdata[RD_LSB+ANGLE_W-1:RD_LSB];
    end
  end

  // p1: squares, half-turn fold
  logic [COORD_BITS-1:0] ae, an;
  logic [2*COORD_BITS-1:0] p1_sqe_r, p1_sqn_r;
  logic signed [XY_W-1:0] x0, y0, ye;
  logic [M_W-1:0] ax0, ay0;
  gbhu_stage_t p1_r, p1_nxt;

  assign ae = COORD_BITS'(p0_de_r[DIFF_W-1] ? -p0_de_r : p0_de_r);
  assign an = COORD_BITS'(p0_dn_r[DIFF_W-1] ? -p0_dn_r : p0_dn_r);
  assign ye = XY_W'(p0_de_r);
  assign x0 = XY_W'($signed({1'b0, an}));
  assign y0 = p0_dn_r[DIFF_W-1] ? -ye : ye;
  assign ax0 = M_W'(an);
  assign ay0 = M_W'(ae);

  always_comb begin
    p1_nxt      = '0;
    p1_nxt.x    = x0;
    p1_nxt.y    = y0;
    p1_nxt.z    = p0_dn_r[DIFF_W-1] ? Z_W'(32'h8000_0000) : '0;
    p1_nxt.m    = (ax0 > ay0) ? ax0 : ay0;
    p1_nxt.zero = (p0_de_r == '0) && (p0_dn_r == '0);
    p1_nxt.sat  = ((64'(ae) >> 31) != 64'd0) || ((64'(an) >> 31) != 64'd0);
    p1_nxt.off  = p0_off_r;
    p1_nxt.rd   = p0_rd_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p1_sqe_r <= ae * ae;
      p1_sqn_r <= an * an;
      p1_r     <= p1_nxt;
    end
  end

  // p2: sum of squares enters the chain
  gbhu_stage_t p2_r, p2_nxt;

  always_comb begin
    p2_nxt      = p1_r;
    p2_nxt.rem  = SQ_W'(p1_sqe_r) + SQ_W'(p1_sqn_r);
    p2_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p2_r <= p2_nxt;
    end
  end

  // chain: one sqrt bit per stage, one normalize/CORDIC step per stage of the bearing path
  gbhu_stage_t st_r [CHAIN_LEN];

  for (genvar j = 0; j < CHAIN_LEN; j++) begin : g_chain
    gbhu_stage_t prv, nxt;
    logic [SQ_W-1:0]        sq_rem;
    logic [ROOT_W-1:0]      sq_root;
    logic signed [XY_W-1:0] bx, by;
    logic [Z_W-1:0]         bz;
    logic [M_W-1:0]         bm;

    if (j == 0) begin : g_first
      assign prv = p2_r;
    end else begin : g_next
      assign prv = st_r[j-1];
    end

    if (j < ROOT_W) begin : g_sqrt
      localparam int B = ROOT_W - 1 - j;
      logic [TRI_W-1:0] trial;
      assign trial = (TRI_W'(prv.root) << (B + 1)) + (TRI_W'(1) << (2 * B));
      always_comb begin
        sq_rem  = prv.rem;
        sq_root = prv.root;
        if (TRI_W'(prv.rem) >= trial) begin
          sq_rem  = prv.rem - trial[SQ_W-1:0];
          sq_root = prv.root | (ROOT_W'(1) << B);
        end
      end
    end else begin : g_sqrt_pass
      assign sq_rem  = prv.rem;
      assign sq_root = prv.root;
    end

    if (j < NORM_STEPS) begin : g_norm
      localparam int K = 32 >> j;
      always_comb begin
        bx = prv.x;
        by = prv.y;
        bm = prv.m;
        if ((prv.m >> (M_W - K)) == '0) begin
          bx = prv.x <<< K;
          by = prv.y <<< K;
          bm = prv.m << K;
        end
      end
      assign bz = prv.z;
    end else if (j < BRG_PATH && (j - NORM_STEPS) < TABLE_LEN) begin : g_cordic
      localparam int I = j - NORM_STEPS;
      always_comb begin
        if (!prv.y[XY_W-1]) begin
          bx = prv.x + (prv.y >>> I);
          by = prv.y - (prv.x >>> I);
          bz = prv.z + ATAN_TURNS[I];
        end else begin
          bx = prv.x - (prv.y >>> I);
          by = prv.y + (prv.x >>> I);
          bz = prv.z - ATAN_TURNS[I];
        end
      end
      assign bm = prv.m;
    end else begin : g_brg_pass
      assign bx = prv.x;
      assign by = prv.y;
      assign bz = prv.z;
      assign bm = prv.m;
    end

    always_comb begin
      nxt      = prv;
      nxt.rem  = sq_rem;
      nxt.root = sq_root;
      nxt.x    = bx;
      nxt.y    = by;
      nxt.z    = bz;
      nxt.m    = bm;
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        st_r[j] <= nxt;
      end
    end
  end

  // t1: round and clamp range, scale angle
  gbhu_stage_t last;
  logic [ROOT_W:0] rnd;
  logic [RANGE_W-1:0] t1_range_r, t1_range_nxt;
  logic [PROD_W-1:0] t1_prod_r;
  logic t1_zero_r;
  logic [ANGLE_W-1:0] t1_off_r, t1_rd_r;

  assign last = st_r[CHAIN_LEN-1];
  assign rnd  = (ROOT_W+1)'(last.root)
              + (ROOT_W+1)'(last.rem > SQ_W'(last.root));
  assign t1_range_nxt = (last.sat || (64'(rnd) > RANGE_MAX)) ? RANGE_W'(RANGE_MAX)
                                                             : RANGE_W'(rnd);

  always_ff @(posedge clk) begin
    if (ce) begin
      t1_range_r <= t1_range_nxt;
      t1_prod_r  <= PROD_W'(last.z) * PROD_W'(CIRCLE_UNITS);
      t1_zero_r  <= last.zero;
      t1_off_r   <= last.off;
      t1_rd_r    <= last.rd;
    end
  end

  // t2: bearing
  logic [PROD_W:0] bsum;
  logic [PROD_W-Z_W:0] bq;
  logic [RANGE_W-1:0] t2_range_r;
  logic [BEARING_W-1:0] t2_brg_r, t2_brg_nxt;
  logic [ANGLE_W-1:0] t2_off_r, t2_rd_r;

  assign bsum = (PROD_W+1)'(t1_prod_r) + (PROD_W+1)'(64'h8000_0000);
  assign bq   = bsum[PROD_W:Z_W];
  assign t2_brg_nxt = (t1_zero_r || (bq >= (PROD_W-Z_W+1)'(CIRCLE_UNITS)))
                    ? '0 : BEARING_W'(bq);

  always_ff @(posedge clk) begin
    if (ce) begin
      t2_range_r <= t1_range_r;
      t2_brg_r   <= t2_brg_nxt;
      t2_off_r   <= t1_off_r;
      t2_rd_r    <= t1_rd_r;
    end
  end

  // t3: bearing minus offset, truncating remainder
  logic signed [HEAD_W:0] diff;
  logic signed [HEAD_W-1:0] t3_head_r, t3_head_nxt;
  logic [RANGE_W-1:0] t3_range_r;
  logic [BEARING_W-1:0] t3_brg_r;
  logic [ANGLE_W-1:0] t3_rd_r;

  assign diff = $signed({2'b00, t2_brg_r}) - $signed({2'b00, t2_off_r});
  assign t3_head_nxt = (diff <= -(HEAD_W+1)'(CIRCLE_UNITS))
                     ? HEAD_W'(diff + (HEAD_W+1)'(CIRCLE_UNITS)) : HEAD_W'(diff);

  always_ff @(posedge clk) begin
    if (ce) begin
      t3_head_r  <= t3_head_nxt;
      t3_range_r <= t2_range_r;
      t3_brg_r   <= t2_brg_r;
      t3_rd_r    <= t2_rd_r;
    end
  end

  // t4: output word
  logic signed [HEAD_W:0] lifted, err;
  logic [RANGE_W-1:0] out_range_r;
  logic [BEARING_W-1:0] out_brg_r;
  logic [HEAD_W-1:0] out_head_r, out_err_r;

  assign lifted = (t3_head_r > 0) ? (HEAD_W+1)'(t3_head_r)
                                  : (HEAD_W+1)'(t3_head_r) + (HEAD_W+1)'(CIRCLE_UNITS);
  assign err = lifted - $signed({2'b00, t3_rd_r});

  always_ff @(posedge clk) begin
    if (ce) begin
      out_range_r <= t3_range_r;
      out_brg_r   <= t3_brg_r;
      out_head_r  <= t3_head_r;
      out_err_r   <= HEAD_W'(err);
    end
  end

  assign out_tvalid = vld_r[NUM_STAGES-1];
  assign out_tdata  = OUT_DATA_W'({out_err_r, out_head_r, out_brg_r, out_range_r});

endmodule

>>> hw/rtl/gbhu_checker.sv
`include "grid_bearing_heading_unit_macros.svh"

module gbhu_checker
  import gbhu_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int BRG_LSB = RANGE_W;

  logic [BEARING_W-1:0] brg;
  assign brg = out_tdata[BRG_LSB+BEARING_W-1:BRG_LSB];

  `GBHU_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output word changed while stalled")
  `GBHU_ASSERT_IMP(a_stall_blocks_in, clk, rst_n, out_tvalid && !out_tready, !in_tready, "input taken while output stalled")
  `GBHU_ASSERT_IMP(a_empty_ready, clk, rst_n, !out_tvalid, in_tready, "input refused with empty output")
  `GBHU_ASSERT_IMP(a_bearing_range, clk, rst_n, out_tvalid, brg < BEARING_W'(CIRCLE_UNITS), "bearing beyond full circle")

endmodule

bind grid_bearing_heading_unit gbhu_checker u_gbhu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> test/tb_grid_bearing_heading_unit.sv
module tb_grid_bearing_heading_unit;
  import gbhu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = NUM_STAGES;
  localparam longint CYCLE_LIMIT = 200000;
  localparam int N_RANDOM = 450;

  typedef struct packed {
    logic [FIELD_COORD_W-1:0] le, ln, te, tn;
    logic [ANGLE_W-1:0]       off, rd;
  } fix_t;

  typedef struct packed {
    logic [RANGE_W-1:0]   range_cm;
    logic [BEARING_W-1:0] bearing;
    logic [HEAD_W-1:0]    rel_head;
    logic [HEAD_W-1:0]    head_err;
  } solution_t;

  // arithmetic right shift, floor semantics
  function automatic longint asr(longint v, int s);
    if (v < 0) return -1 - longint'(longint'(unsigned'(-1 - v)) >>> s);
    return v >>> s;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned s,
                                            output longint unsigned rem);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    rem = s;
    return r;
  endfunction

  function automatic solution_t solve_fix(fix_t f);
    longint de, dn, x, y, nx, off, rd, brg, head, lifted, err;
    longint unsigned ae, an, rem, r, z, b;
    solution_t s;
    de = longint'(f.te[COORD_BITS-1:0]) - longint'(f.le[COORD_BITS-1:0]);
    dn = longint'(f.tn[COORD_BITS-1:0]) - longint'(f.ln[COORD_BITS-1:0]);
    off = longint'(f.off);
    rd = longint'(f.rd);
    ae = de < 0 ? -de : de;
    an = dn < 0 ? -dn : dn;
    if (ae >= 64'h8000_0000 || an >= 64'h8000_0000) begin
      r = RANGE_MAX;
    end else begin
      r = isqrt(ae * ae + an * an, rem);
      if (rem > r) r++;
      if (r > RANGE_MAX) r = RANGE_MAX;
    end
    if (de == 0 && dn == 0) begin
      brg = 0;
    end else begin
      x = dn;
      y = de;
      z = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 64'h8000_0000;
      end
      while ((x < 0 ? -x : x) < (64'd1 << 40) && (y < 0 ? -y : y) < (64'd1 << 40)) begin
        x = x * 2;
        y = y * 2;
      end
      for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
        if (y >= 0) begin
          nx = x + asr(y, i);
          y = y - asr(x, i);
          z = z + ATAN_TURNS[i];
        end else begin
          nx = x - asr(y, i);
          y = y + asr(x, i);
          z = z - ATAN_TURNS[i];
        end
        x = nx;
        z = z & 64'hFFFF_FFFF;
      end
      b = (z * CIRCLE_UNITS + 64'h8000_0000) >> 32;
      brg = b >= CIRCLE_UNITS ? 0 : longint'(b);
    end
    head = (brg - off) % CIRCLE_UNITS;
    lifted = head > 0 ? head : head + CIRCLE_UNITS;
    err = lifted - rd;
    s.range_cm = r[RANGE_W-1:0];
    s.bearing = brg[BEARING_W-1:0];
    s.rel_head = head[HEAD_W-1:0];
    s.head_err = err[HEAD_W-1:0];
    return s;
  endfunction

  class solution_board;
    solution_t pending[$];
    int errors;

    function void note_fix(fix_t f);
      pending.push_back(solve_fix(f));
    endfunction

    function void check_solution(solution_t got);
      solution_t want;
      if (pending.size() == 0) begin
        report(got, got, "unexpected word");
        return;
      end
      want = pending.pop_front();
      if (got.range_cm !== want.range_cm) report(want, got, "range_cm");
      else if (got.bearing !== want.bearing) report(want, got, "bearing");
      else if (got.rel_head !== want.rel_head) report(want, got, "relative_heading");
      else if (got.head_err !== want.head_err) report(want, got, "heading_error");
    endfunction

    function void report(solution_t want, solution_t got, string what);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: exp rng=%0d brg=%0d rh=%0d he=%0d",
                 what, want.range_cm, want.bearing, $signed(want.rel_head),
                 $signed(want.head_err),
                 " got rng=%0d brg=%0d rh=%0d he=%0d", got.range_cm, got.bearing,
                 $signed(got.rel_head), $signed(got.head_err));
    endfunction
  endclass

  logic clk, rst_n, in_tvalid, in_tready, out_tvalid, out_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [OUT_DATA_W-1:0] out_tdata;
  solution_board board;
  longint cycles;
  bit calm;  // no idling in the final stretch

  grid_bearing_heading_unit dut (.*);

  function automatic logic [IN_DATA_W-1:0] pack_fix(fix_t f);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[FIELD_COORD_W*0 +: FIELD_COORD_W] = f.le;
    d[FIELD_COORD_W*1 +: FIELD_COORD_W] = f.ln;
    d[FIELD_COORD_W*2 +: FIELD_COORD_W] = f.te;
    d[FIELD_COORD_W*3 +: FIELD_COORD_W] = f.tn;
    d[FIELD_COORD_W*4 +: ANGLE_W] = f.off;
    d[FIELD_COORD_W*4+ANGLE_W +: ANGLE_W] = f.rd;
    return d;
  endfunction

  function automatic solution_t unpack_solution(logic [OUT_DATA_W-1:0] d);
    solution_t s;
    s.range_cm = d[0 +: RANGE_W];
    s.bearing = d[RANGE_W +: BEARING_W];
    s.rel_head = d[RANGE_W+BEARING_W +: HEAD_W];
    s.head_err = d[RANGE_W+BEARING_W+HEAD_W +: HEAD_W];
    return s;
  endfunction

  function automatic logic [29:0] rand_coord(int mode);
    case (mode)
      0: return 30'($urandom_range(1000000000, 0));
      1: return 30'($urandom());  // full 30 bits, beyond the nominal range
      default: return 30'($urandom_range(1000, 0));
    endcase
  endfunction

  function automatic fix_t rand_fix();
    fix_t f;
    int mode;
    mode = $urandom_range(2, 0);
    f.le = rand_coord(mode);
    f.ln = rand_coord(mode);
    if (mode == 2) begin
      f.le = f.le + 30'd500000000;
      f.ln = f.ln + 30'd500000000;
      f.te = 30'(f.le + $urandom_range(2000, 0) - 1000);
      f.tn = 30'(f.ln + $urandom_range(2000, 0) - 1000);
    end else begin
      f.te = rand_coord(mode);
      f.tn = rand_coord(mode);
    end
    if ($urandom_range(3, 0) == 0) f.te = f.le;
    else if ($urandom_range(3, 0) == 0) f.tn = f.ln;
    f.off = ($urandom_range(7, 0) == 0) ? 20'($urandom()) : 20'($urandom_range(639999, 0));
    f.rd = ($urandom_range(7, 0) == 0) ? 20'($urandom()) : 20'($urandom_range(639999, 0));
    return f;
  endfunction

  task automatic send_fix(fix_t f);
    if (!calm && $urandom_range(5, 0) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pack_fix(f);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_fix(f);
    @(negedge clk);
  endtask

  task automatic send_corner(int unsigned le, ln, te, tn, off, rd);
    fix_t f;
    f.le = 30'(le); f.ln = 30'(ln); f.te = 30'(te); f.tn = 30'(tn);
    f.off = 20'(off); f.rd = 20'(rd);
    send_fix(f);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side: sample at the rising edge, stall at the falling edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_solution(unpack_solution(out_tdata));
  end

  initial begin
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_tready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if ($urandom_range(7, 0) == 0) begin
        stall = $urandom_range(14, 1) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    board = new();
    calm = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners
    send_corner(0, 0, 0, 0, 0, 0);                        // equal points
    send_corner(5, 5, 5, 5, 639999, 639999);
    send_corner(0, 0, 0, 1000, 0, 0);                     // north
    send_corner(0, 0, 1000, 0, 0, 0);                     // east
    send_corner(0, 1000, 0, 0, 0, 0);                     // south
    send_corner(1000, 0, 0, 0, 0, 0);                     // west
    send_corner(0, 1, 0, 0, 0, 0);                        // due south, unit distance
    send_corner(0, 1000, 1, 0, 0, 0);
    send_corner(1, 1000, 0, 0, 0, 0);
    send_corner(0, 0, 1000000000, 1000000000, 320000, 100);
    send_corner(1000000000, 1000000000, 0, 0, 639999, 0);
    send_corner(0, 0, 30'h3FFFFFFF, 30'h3FFFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_corner(30'h3FFFFFFF, 30'h3FFFFFFF, 0, 0, 20'hFFFFF, 0);
    send_corner(30'h3FFFFFFF, 0, 0, 30'h3FFFFFFF, 0, 20'hFFFFF);
    send_corner(0, 0, 1, 1, 80000, 639999);               // heading exactly zero
    send_corner(0, 0, 3, 4, 639999, 1);
    send_corner(7, 3, 2, 9, 700000, 640000);
    send_corner(0, 0, 1, 0, 160000, 0);                   // heading exactly zero
    send_corner(0, 0, 0, 1, 1, 0);                        // negative heading
    send_corner(12345, 67890, 13345, 66890, 20'h55555, 20'hAAAAA);

    // hold off until the pipe drains
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 60) calm = 1'b1;
      send_fix(rand_fix());
    end
    in_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> grid_bearing_heading_unit.f
+incdir+hw/rtl
hw/rtl/gbhu_pkg.sv
hw/rtl/grid_bearing_heading_unit.sv
hw/rtl/gbhu_checker.sv
test/tb_grid_bearing_heading_unit.sv
